// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off while arst_n is low
`define TFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// next-cycle implication built on the check above
`define TFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	`TFB_ASSERT(lbl, ante |=> cons, msg)

`endif

// File: hdl/tfb_pkg.sv
// shared constants, types and functions of the telemetry frame builder
package tfb_pkg;

	localparam int FRAME_BYTES = 46;
	localparam int BODY_BYTES  = FRAME_BYTES - 2;
	localparam int BODY_W      = BODY_BYTES * 8;
	localparam int POS_W       = 6;

	localparam logic [7:0]  MAGIC0     = 8'hC5;
	localparam logic [7:0]  MAGIC1     = 8'h5A;
	localparam logic [7:0]  VERSION    = 8'h01;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;

	// n / 100 for any 32-bit unsigned n is (n * DIV100_RECIP) >> DIV100_SHIFT
	localparam logic [31:0] DIV100_RECIP = 32'h51EB851F;
	localparam int          DIV100_SHIFT = 37;

	typedef struct packed {
		logic load;
		logic shift;
	} chain_ctl_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: hdl/tfb_cell.sv
// one byte cell of the frame chain
module tfb_cell
	import tfb_pkg::*;
(
	input  logic       clk,
	input  chain_ctl_t ctl,
	input  logic [7:0] load_byte,
	input  logic [7:0] next_byte,
	output logic [7:0] cell_byte
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= load_byte;
		end else if (ctl.shift) begin
			byte_q <= next_byte;
		end
	end

	assign cell_byte = byte_q;

endmodule

// File: hdl/tfb_chain.sv
// row of byte cells holding the frame body, shifting toward the head
module tfb_chain
	import tfb_pkg::*;
(
	input  logic              clk,
	input  chain_ctl_t        ctl,
	input  logic [BODY_W-1:0] body,
	output logic [7:0]        head_byte
);

	logic [7:0] cell_bytes [BODY_BYTES];

	for (genvar i = 0; i < BODY_BYTES; i++) begin : g_cell
		logic [7:0] next_byte;
		if (i == BODY_BYTES - 1) begin : g_tail
			assign next_byte = 8'h00;
		end else begin : g_mid
			assign next_byte = cell_bytes[i + 1];
		end
		tfb_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.load_byte (body[8*i +: 8]),
			.next_byte (next_byte),
			.cell_byte (cell_bytes[i])
		);
	end

	assign head_byte = cell_bytes[0];

endmodule

// File: hdl/tfb_crc.sv
// running crc-16 over the body bytes as they leave the chain head
module tfb_crc
	import tfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  chain_ctl_t  ctl,
	input  logic [7:0]  data_byte,
	output logic [15:0] crc
);

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.load) begin
			crc_q <= CRC_INIT;
		end else if (ctl.shift) begin
			crc_q <= crc_update(crc_q, data_byte);
		end
	end

	assign crc = crc_q;

endmodule

// File: hdl/tfb_front.sv
// two-stage record pipeline: capture, altitude scaling to decimeters, body assembly
module tfb_front
	import tfb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                record_valid,
	output logic                record_stall,
	input  logic [1:0]          valid_flags,
	input  logic [31:0]         frame_sequence,
	input  logic [63:0]         timestamp_ms,
	input  logic [47:0]         attitude_packed,
	input  logic [7:0]          fix_type,
	input  logic [7:0]          satellite_count,
	input  logic signed [31:0]  lat_e7,
	input  logic signed [31:0]  lon_e7,
	input  logic signed [31:0]  alt_msl_mm,
	input  logic signed [31:0]  alt_rel_mm,
	input  logic [47:0]         velocity_packed,
	input  logic [15:0]         heading_cdeg,
	output logic                body_valid,
	input  logic                body_take,
	output logic [BODY_W-1:0]   body
);

	// bytes 32..35 carry the two altitudes, filled in after the divide
	localparam int ALT_LO = 32 * 8;
	localparam int ALT_HI = 36 * 8;

	logic              s1_valid_q;
	logic              s2_valid_q;
	logic              s1_adv;
	logic              s2_adv;
	logic              accept;
	logic [BODY_W-1:0] body_s1;
	logic [31:0]       alt_s1;
	logic [31:0]       ralt_s1;
	logic [BODY_W-1:0] body_s2;
	logic [15:0]       alt_q_s2;
	logic [15:0]       ralt_q_s2;
	logic              alt_neg_s2;
	logic              ralt_neg_s2;
	logic [31:0]       alt_mag;
	logic [31:0]       ralt_mag;
	logic [63:0]       alt_prod;
	logic [63:0]       ralt_prod;
	logic [15:0]       alt_dm;
	logic [15:0]       ralt_dm;

	assign s2_adv       = !s2_valid_q || body_take;
	assign s1_adv       = !s1_valid_q || s2_adv;
	assign accept       = record_valid && s1_adv;
	assign record_stall = !s1_adv;
	assign body_valid   = s2_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				s1_valid_q <= record_valid;
			end
			if (s2_adv) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			body_s1 <= {heading_cdeg, velocity_packed, 32'h0000_0000,
				unsigned'(lon_e7), unsigned'(lat_e7),
				satellite_count, fix_type, attitude_packed, timestamp_ms,
				frame_sequence, 6'b000000, valid_flags, VERSION, MAGIC1, MAGIC0};
			alt_s1  <= unsigned'(alt_msl_mm);
			ralt_s1 <= unsigned'(alt_rel_mm);
		end
	end

	// magnitude times reciprocal, truncation toward zero then sign restored
	assign alt_mag   = alt_s1[31] ? (~alt_s1 + 32'd1) : alt_s1;
	assign ralt_mag  = ralt_s1[31] ? (~ralt_s1 + 32'd1) : ralt_s1;
	assign alt_prod  = alt_mag * DIV100_RECIP;
	assign ralt_prod = ralt_mag * DIV100_RECIP;

	always_ff @(posedge clk) begin
		if (s2_adv && s1_valid_q) begin
			body_s2     <= body_s1;
			alt_q_s2    <= alt_prod[DIV100_SHIFT +: 16];
			ralt_q_s2   <= ralt_prod[DIV100_SHIFT +: 16];
			alt_neg_s2  <= alt_s1[31];
			ralt_neg_s2 <= ralt_s1[31];
		end
	end

	assign alt_dm  = alt_neg_s2 ? (~alt_q_s2 + 16'd1) : alt_q_s2;
	assign ralt_dm = ralt_neg_s2 ? (~ralt_q_s2 + 16'd1) : ralt_q_s2;
	assign body    = {body_s2[BODY_W-1:ALT_HI], ralt_dm, alt_dm, body_s2[ALT_LO-1:0]};

endmodule

// File: hdl/telemetry_frame_builder_crc16.sv
// telemetry frame builder: record in, 46-byte little-endian frame with crc-16 out
// a record passes the front stages, then loads the chain, which raises byte_valid
// output: one byte per cycle while byte_stall is low, from the 44-cell
// byte chain draining at its head followed by the two crc bytes
// a record waits in the two front stages while a frame drains
// reset clears the stage valids, frame position, busy flag and crc; cells are not reset
module telemetry_frame_builder_crc16
	import tfb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               record_valid,
	output logic               record_stall,
	input  logic [1:0]         valid_flags,
	input  logic [31:0]        frame_sequence,
	input  logic [63:0]        timestamp_ms,
	input  logic [47:0]        attitude_packed,
	input  logic [7:0]         fix_type,
	input  logic [7:0]         satellite_count,
	input  logic signed [31:0] lat_e7,
	input  logic signed [31:0] lon_e7,
	input  logic signed [31:0] alt_msl_mm,
	input  logic signed [31:0] alt_rel_mm,
	input  logic [47:0]        velocity_packed,
	input  logic [15:0]        heading_cdeg,
	output logic               byte_valid,
	input  logic               byte_stall,
	output logic [7:0]         frame_byte,
	output logic               last_byte
);

	localparam logic [POS_W-1:0] BODY_END = POS_W'(BODY_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	logic              body_valid;
	logic [BODY_W-1:0] body;
	logic              busy_q;
	logic [POS_W-1:0]  pos_q;
	logic              out_take;
	logic              at_last;
	logic              in_body;
	chain_ctl_t        ctl;
	logic [7:0]        head_byte;
	logic [15:0]       crc;

	tfb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.record_valid    (record_valid),
		.record_stall    (record_stall),
		.valid_flags     (valid_flags),
		.frame_sequence  (frame_sequence),
		.timestamp_ms    (timestamp_ms),
		.attitude_packed (attitude_packed),
		.fix_type        (fix_type),
		.satellite_count (satellite_count),
		.lat_e7          (lat_e7),
		.lon_e7          (lon_e7),
		.alt_msl_mm      (alt_msl_mm),
		.alt_rel_mm      (alt_rel_mm),
		.velocity_packed (velocity_packed),
		.heading_cdeg    (heading_cdeg),
		.body_valid      (body_valid),
		.body_take       (ctl.load),
		.body            (body)
	);

	assign out_take  = busy_q && !byte_stall;
	assign at_last   = pos_q == LAST_POS;
	assign in_body   = pos_q < BODY_END;
	// next frame loads in the same cycle the last byte of this one is taken
	assign ctl.load  = body_valid && (!busy_q || (out_take && at_last));
	assign ctl.shift = out_take && in_body;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (out_take) begin
			if (at_last) begin
				busy_q <= 1'b0;
				pos_q  <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	tfb_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.body      (body),
		.head_byte (head_byte)
	);

	tfb_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_byte (head_byte),
		.crc       (crc)
	);

	assign byte_valid = busy_q;
	assign last_byte  = at_last;
	assign frame_byte = in_body ? head_byte : (at_last ? crc[15:8] : crc[7:0]);

endmodule

// File: hdl/tfb_checker.sv
// port-level checks of the frame builder, bound to the top level
`include "assert_macros.svh"

module tfb_checker
	import tfb_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] frame_byte,
	input logic       last_byte
);

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] FLAGS_POS = POS_W'(3);

	logic [POS_W-1:0] cnt_q;
	logic             take;
	logic             stalled;
	logic             at_first;
	logic             at_flags;
	logic             at_end;
	logic [8:0]       out_word;

	assign take     = byte_valid && !byte_stall;
	assign stalled  = byte_valid && byte_stall;
	assign at_first = cnt_q == '0;
	assign at_flags = cnt_q == FLAGS_POS;
	assign at_end   = cnt_q == LAST_POS;
	assign out_word = {frame_byte, last_byte};

	// word count within the current frame as seen on the output port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= last_byte ? '0 : cnt_q + POS_W'(1);
		end
	end

	`TFB_ASSERT(a_last_on_final, byte_valid |-> (last_byte == at_end), "last_byte misplaced")
	`TFB_ASSERT(a_magic_first, (byte_valid && at_first) |-> (frame_byte == MAGIC0), "no magic word")
	`TFB_ASSERT(a_flags_upper, (byte_valid && at_flags) |-> (frame_byte[7:2] == '0), "flags bits")
	`TFB_ASSERT_NEXT(a_hold_stalled, stalled, byte_valid && $stable(out_word), "stalled word moved")

endmodule

bind telemetry_frame_builder_crc16 tfb_checker u_tfb_checker (.*);

// File: dv/telemetry_frame_builder_crc16_tb.sv
// testbench for the telemetry frame builder: records in, checked frame words out
module telemetry_frame_builder_crc16_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN = 46;
	localparam int BODY_LEN = FRAME_LEN - 2;
	localparam logic [7:0] SYNC_LO = 8'hC5;
	localparam logic [7:0] SYNC_HI = 8'h5A;
	localparam logic [7:0] FORMAT_VER = 8'h01;
	localparam logic [15:0] CRC_POLYNOMIAL = 16'h1021;
	localparam logic [15:0] CRC_START = 16'hFFFF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_PRINTED = 20;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct packed {
		logic [1:0] valid_flags;
		logic [31:0] frame_sequence;
		logic [63:0] timestamp_ms;
		logic [47:0] attitude_packed;
		logic [7:0] fix_type;
		logic [7:0] satellite_count;
		logic signed [31:0] lat_e7;
		logic signed [31:0] lon_e7;
		logic signed [31:0] alt_msl_mm;
		logic signed [31:0] alt_rel_mm;
		logic [47:0] velocity_packed;
		logic [15:0] heading_cdeg;
	} record_t;

	typedef struct packed {
		logic [7:0] value;
		logic last;
	} frame_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic record_valid = 1'b0;
	logic record_stall;
	logic [1:0] valid_flags = '0;
	logic [31:0] frame_sequence = '0;
	logic [63:0] timestamp_ms = '0;
	logic [47:0] attitude_packed = '0;
	logic [7:0] fix_type = '0;
	logic [7:0] satellite_count = '0;
	logic signed [31:0] lat_e7 = '0;
	logic signed [31:0] lon_e7 = '0;
	logic signed [31:0] alt_msl_mm = '0;
	logic signed [31:0] alt_rel_mm = '0;
	logic [47:0] velocity_packed = '0;
	logic [15:0] heading_cdeg = '0;
	logic byte_valid;
	logic byte_stall = 1'b0;
	logic [7:0] frame_byte;
	logic last_byte;

	frame_word_t expected_words[$];
	int mismatch_count = 0;
	int records_sent = 0;
	int words_checked = 0;
	int frames_closed = 0;
	int drain_pauses = 0;
	int cycle_count = 0;

	// sender burst control
	bit tx_gaps_on = 1'b1;
	int burst_left = 0;

	// receiver stall pattern
	bit rx_quiet = 1'b0;
	stall_mode_t rx_mode = STALL_NONE;
	int rx_phase_left = 0;

	telemetry_frame_builder_crc16 dut (
		.clk(clk),
		.arst_n(arst_n),
		.record_valid(record_valid),
		.record_stall(record_stall),
		.valid_flags(valid_flags),
		.frame_sequence(frame_sequence),
		.timestamp_ms(timestamp_ms),
		.attitude_packed(attitude_packed),
		.fix_type(fix_type),
		.satellite_count(satellite_count),
		.lat_e7(lat_e7),
		.lon_e7(lon_e7),
		.alt_msl_mm(alt_msl_mm),
		.alt_rel_mm(alt_rel_mm),
		.velocity_packed(velocity_packed),
		.heading_cdeg(heading_cdeg),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.frame_byte(frame_byte),
		.last_byte(last_byte)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_count,
				expected_words.size());
			$display("telemetry_frame_builder_crc16: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("[%0t] error: %s", $realtime, msg);
	endtask

	// millimeters to decimeters, truncated toward zero, wrapped to 16 bits
	function automatic logic [15:0] mm_to_dm16(input logic signed [31:0] mm);
		int q;
		q = mm / 100;
		return q[15:0];
	endfunction

	// build the frame of one record and queue its words
	task automatic queue_frame_of(input record_t r);
		logic [BODY_LEN*8-1:0] body;
		logic [15:0] crc;
		body = {r.heading_cdeg, r.velocity_packed, mm_to_dm16(r.alt_rel_mm),
			mm_to_dm16(r.alt_msl_mm), r.lon_e7, r.lat_e7, r.satellite_count,
			r.fix_type, r.attitude_packed, r.timestamp_ms, r.frame_sequence,
			{6'b0, r.valid_flags}, FORMAT_VER, SYNC_HI, SYNC_LO};
		crc = CRC_START;
		for (int k = 0; k < BODY_LEN; k++) begin
			crc = crc ^ {body[8*k +: 8], 8'h00};
			for (int j = 0; j < 8; j++)
				crc = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLYNOMIAL) : {crc[14:0], 1'b0};
			expected_words.push_back('{value: body[8*k +: 8], last: 1'b0});
		end
		expected_words.push_back('{value: crc[7:0], last: 1'b0});
		expected_words.push_back('{value: crc[15:8], last: 1'b1});
	endtask

	task automatic drive_fields(input record_t r);
		valid_flags = r.valid_flags;
		frame_sequence = r.frame_sequence;
		timestamp_ms = r.timestamp_ms;
		attitude_packed = r.attitude_packed;
		fix_type = r.fix_type;
		satellite_count = r.satellite_count;
		lat_e7 = r.lat_e7;
		lon_e7 = r.lon_e7;
		alt_msl_mm = r.alt_msl_mm;
		alt_rel_mm = r.alt_rel_mm;
		velocity_packed = r.velocity_packed;
		heading_cdeg = r.heading_cdeg;
	endtask

	function automatic logic signed [31:0] rand_mm();
		int k;
		case ($urandom_range(0, 5))
			0: return $signed(32'($urandom_range(0, 4000))) - 32'sd2000;
			1: begin
				k = $signed(32'($urandom_range(0, 42949670))) - 21474835;
				return k * 100 + ($signed(32'($urandom_range(0, 2))) - 1);
			end
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sh80000000;
					1: return 32'sh7FFFFFFF;
					2: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			// around the points where the decimeter value wraps
			3: return ($urandom_range(0, 1) ? 32'sd3276800 : -32'sd3276900)
				+ $signed(32'($urandom_range(0, 400))) - 32'sd200;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic record_t rand_record();
		record_t r;
		logic [63:0] w;
		r.valid_flags = 2'($urandom_range(0, 3));
		r.frame_sequence = $urandom;
		r.timestamp_ms = {$urandom, $urandom};
		w = {$urandom, $urandom};
		r.attitude_packed = ($urandom_range(0, 7) == 0) ? {3{16'h8000}} : w[47:0];
		r.fix_type = 8'($urandom);
		r.satellite_count = 8'($urandom);
		r.lat_e7 = ($urandom_range(0, 7) == 0) ? 32'sh80000000 : $signed($urandom);
		r.lon_e7 = ($urandom_range(0, 7) == 0) ? 32'sh7FFFFFFF : $signed($urandom);
		r.alt_msl_mm = rand_mm();
		r.alt_rel_mm = rand_mm();
		w = {$urandom, $urandom};
		r.velocity_packed = ($urandom_range(0, 7) == 0) ? {3{16'h7FFF}} : w[47:0];
		r.heading_cdeg = 16'($urandom);
		return r;
	endfunction

	// offer one record, hold it until accepted, then queue its frame
	task automatic send_record(input record_t r);
		int gap;
		gap = 0;
		if (tx_gaps_on && burst_left <= 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 8);
		end
		@(negedge clk);
		if (gap > 0) begin
			record_valid = 1'b0;
			drive_fields(rand_record());
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		drive_fields(r);
		record_valid = 1'b1;
		@(posedge clk);
		while (record_stall !== 1'b0)
			@(posedge clk);
		queue_frame_of(r);
		records_sent++;
		burst_left--;
	endtask

	task automatic wait_frames_done();
		@(negedge clk);
		record_valid = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (rx_phase_left <= 0) begin
			rx_mode = stall_mode_t'($urandom_range(0, 3));
			rx_phase_left = $urandom_range(20, 120);
		end else begin
			rx_phase_left--;
		end
		if (rx_quiet) begin
			byte_stall = 1'b0;
		end else begin
			case (rx_mode)
				STALL_NONE: byte_stall = 1'b0;
				STALL_LIGHT: byte_stall = ($urandom_range(0, 3) == 0);
				STALL_HEAVY: byte_stall = ($urandom_range(0, 3) != 0);
				default: byte_stall = ((rx_phase_left % 8) < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		frame_word_t exp_word;
		if (arst_n) begin
			if ($isunknown(byte_valid)) begin
				report_mismatch("byte_valid is unknown");
			end else if (byte_valid && !byte_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %02h with nothing expected", frame_byte));
				end else begin
					exp_word = expected_words.pop_front();
					if (frame_byte !== exp_word.value)
						report_mismatch($sformatf("word %0d of frame %0d: frame_byte %02h, want %02h",
							words_checked % FRAME_LEN, frames_closed, frame_byte, exp_word.value));
					if (last_byte !== exp_word.last)
						report_mismatch($sformatf("word %0d of frame %0d: last_byte %b, want %b",
							words_checked % FRAME_LEN, frames_closed, last_byte, exp_word.last));
					words_checked++;
					if (exp_word.last)
						frames_closed++;
				end
			end
		end
	end

	task automatic test_directed();
		record_t r;
		tx_gaps_on = 1'b0;
		r = '0;
		send_record(r);
		r = '1;
		send_record(r);
		r = '0;
		r.valid_flags = 2'd1;
		r.frame_sequence = 32'hAAAA_AAAA;
		r.timestamp_ms = 64'hAAAA_AAAA_AAAA_AAAA;
		r.attitude_packed = {3{16'h8000}};
		r.fix_type = 8'hAA;
		r.satellite_count = 8'h55;
		r.lat_e7 = 32'sh80000000;
		r.lon_e7 = 32'sh80000000;
		r.alt_msl_mm = 32'sh80000000;
		r.alt_rel_mm = 32'sh80000000;
		r.velocity_packed = {3{16'h8000}};
		r.heading_cdeg = 16'hAAAA;
		send_record(r);
		r = '0;
		r.valid_flags = 2'd2;
		r.frame_sequence = 32'h5555_5555;
		r.timestamp_ms = 64'h5555_5555_5555_5555;
		r.attitude_packed = {3{16'h7FFF}};
		r.fix_type = 8'h55;
		r.satellite_count = 8'hAA;
		r.lat_e7 = 32'sh7FFFFFFF;
		r.lon_e7 = 32'sh7FFFFFFF;
		r.alt_msl_mm = 32'sh7FFFFFFF;
		r.alt_rel_mm = 32'sh7FFFFFFF;
		r.velocity_packed = {3{16'h7FFF}};
		r.heading_cdeg = 16'h5555;
		send_record(r);
		// division rounds toward zero on both sides of zero
		r = '0;
		r.valid_flags = 2'd3;
		r.alt_msl_mm = -32'sd99;
		r.alt_rel_mm = 32'sd99;
		send_record(r);
		r.alt_msl_mm = -32'sd100;
		r.alt_rel_mm = 32'sd100;
		send_record(r);
		r.alt_msl_mm = -32'sd101;
		r.alt_rel_mm = 32'sd199;
		send_record(r);
		r.alt_msl_mm = -32'sd199;
		r.alt_rel_mm = 32'sd201;
		send_record(r);
		// decimeter value wraps past 16 bits
		r.alt_msl_mm = 32'sd6553599;
		r.alt_rel_mm = 32'sd6553600;
		send_record(r);
		r.alt_msl_mm = -32'sd3276900;
		r.alt_rel_mm = 32'sd3276800;
		send_record(r);
		// single bits at the ends of the wide fields
		r = '0;
		r.frame_sequence = 32'h8000_0001;
		r.timestamp_ms = 64'h8000_0000_0000_0001;
		r.attitude_packed = 48'h8000_0000_0001;
		r.velocity_packed = 48'h8000_0000_0001;
		r.heading_cdeg = 16'h8001;
		send_record(r);
		// same record back to back, nothing may carry over
		r = rand_record();
		repeat (3) send_record(r);
		wait_frames_done();
	endtask

	task automatic test_back_to_back();
		tx_gaps_on = 1'b0;
		rx_quiet = 1'b1;
		repeat (40) send_record(rand_record());
		rx_quiet = 1'b0;
		repeat (20) send_record(rand_record());
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_drain_pauses();
		repeat (8) begin
			repeat ($urandom_range(1, 4)) send_record(rand_record());
			wait_frames_done();
			drain_pauses++;
		end
	endtask

	task automatic test_random_traffic();
		tx_gaps_on = 1'b1;
		repeat (250) send_record(rand_record());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);
		test_directed();
		test_back_to_back();
		test_drain_pauses();
		test_random_traffic();
		wait_frames_done();
		$display("sent %0d records (directed extremes, altitude rounding and wrap, back to back)",
			records_sent);
		$display("checked %0d words in %0d frames, %0d drain pauses, random gaps and stalls",
			words_checked, frames_closed, drain_pauses);
		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("telemetry_frame_builder_crc16: match");
		end else begin
			$display("%0d mismatches, %0d words left over", mismatch_count,
				expected_words.size());
			$display("telemetry_frame_builder_crc16: mismatch");
		end
		$finish;
	end

endmodule

// File: telemetry_frame_builder_crc16.f
+incdir+hdl
hdl/tfb_pkg.sv
hdl/tfb_cell.sv
hdl/tfb_chain.sv
hdl/tfb_crc.sv
hdl/tfb_front.sv
hdl/telemetry_frame_builder_crc16.sv
hdl/tfb_checker.sv
dv/telemetry_frame_builder_crc16_tb.sv
